/* sv/trimmed_mean_population_estimator_core_defines.svh */
// ----------------------------------------------------------------------------
// trimmed_mean_population_estimator_core_defines
// Assertion macros used by the estimator back end (tmpe_back).
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_POPULATION_ESTIMATOR_CORE_DEFINES_SVH
`define TRIMMED_MEAN_POPULATION_ESTIMATOR_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define TMPE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define TMPE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tmpe_pkg.sv */
// ----------------------------------------------------------------------------
// tmpe_pkg
// Shared constants and types of the trimmed-mean population estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package tmpe_pkg;

  localparam int WINDOW      = 100;
  localparam int MIN_SAMPLES = 10;
  localparam int ADDR_W      = $clog2(WINDOW);
  localparam int CNT_W       = $clog2(WINDOW + 1);
  localparam int PROBE_W     = 31;
  localparam int SUM_W       = PROBE_W + CNT_W;
  localparam int MOD_W       = 34;

  localparam logic [16:0] MOD_OLD_Q16 = 17'd78643;
  localparam logic [16:0] MOD_FW_Q16  = 17'd91750;
  localparam logic [16:0] ONE_Q16     = 17'd65536;

  // n/6 as (n*171)>>10, exact for n below 257
  localparam logic [7:0] CUT_RECIP = 8'd171;
  localparam int         CUT_SHIFT = 10;

  localparam logic [1:0] CFG_FIREWALLED_UDP = 2'd0;
  localparam logic [1:0] CFG_FW_RATIO       = 2'd1;
  localparam logic [1:0] CFG_NEWER_RATIO    = 2'd2;

  typedef struct packed {
    logic        firewalled_udp;
    logic [15:0] firewalled_ratio_q16;
    logic [16:0] newer_node_ratio_q16;
  } cfg_t;

  typedef struct packed {
    logic               has_probe;
    logic [PROBE_W-1:0] probe;
  } probe_item_t;

  typedef struct packed {
    logic        probe_added;
    logic [6:0]  probe_count;
    logic [31:0] estimate;
  } result_t;

endpackage

`default_nettype wire

/* sv/trimmed_mean_population_estimator_core.sv */
// ----------------------------------------------------------------------------
// trimmed_mean_population_estimator_core
// Turns closest-node distances into a trimmed-mean population estimate.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one distance item (tdata[31:0] = distance_high). Each item
//   yields exactly one result item on m_axis.
//   cfg writes a register (index 0 firewalled_udp, 1 firewalled_ratio_q16,
//   2 newer_node_ratio_q16); cfg_ready is always high; write only when idle.
//   Front: accepts an item, then divides bit-serially for the probe (a zero
//   distance skips the division). Back: sorted merge of the window in ST_MA
//   and ST_MB per held probe, trimmed sum in ST_SA and ST_SB per kept probe,
//   a 38-step mean divider and scaling in ST_MOD1, ST_MOD2 and ST_MUL1 to
//   ST_MUL3. The merge and sum passes read the sorted RAM entry by entry and
//   take most of an item's time. Front and back overlap through a 2-item
//   queue.
// Reset clears window count, ring pointer, queue and configuration; window
// memories need no clearing since only the held entries are ever read.
// A stalled m_axis holds the result in the output register; the back then
// waits before its next result while the front keeps taking input items until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_mean_population_estimator_core import tmpe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] distance_high
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [31:0] estimate, [38:32] probe_count,
                                           // [39] probe_added
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  cfg_t        cfg;
  probe_item_t front_item;
  probe_item_t back_item;
  result_t     res;
  logic        push_valid;
  logic        push_ready;
  logic        pop_valid;
  logic        pop_ready;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIREWALLED_UDP: cfg.firewalled_udp       <= cfg_data[0];
        CFG_FW_RATIO:       cfg.firewalled_ratio_q16 <= cfg_data[15:0];
        CFG_NEWER_RATIO:    cfg.newer_node_ratio_q16 <= cfg_data;
        default:            cfg                      <= cfg;
      endcase
    end
  end

  tmpe_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .distance_high(s_axis_tdata),
    .push_valid(push_valid), .push_ready(push_ready), .push_item(front_item)
  );

  tmpe_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(push_valid), .wr_ready(push_ready), .wr_item(front_item),
    .rd_valid(pop_valid), .rd_ready(pop_ready), .rd_item(back_item)
  );

  tmpe_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(back_item),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
  );

  assign m_axis_tdata = {res.probe_added, res.probe_count, res.estimate};

endmodule

`default_nettype wire

/* sv/tmpe_ram.sv */
// ----------------------------------------------------------------------------
// tmpe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmpe_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 100,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/tmpe_front.sv */
// ----------------------------------------------------------------------------
// tmpe_front
// Accepts distance items; divides each nonzero one bit-serially into a probe.
// ----------------------------------------------------------------------------
`default_nettype none

module tmpe_front import tmpe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] distance_high,
  output logic             push_valid,
  input  wire logic        push_ready,
  output probe_item_t      push_item
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]  state;
  logic [31:0] divisor;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [4:0]  cnt;
  logic        has;
  logic [32:0] shifted;
  logic        fits;

  assign shifted = {rem, quo[31]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            divisor <= distance_high;
            rem     <= '0;
            quo     <= 32'hFFFF_FFFF;
            cnt     <= '0;
            has     <= (distance_high != 32'd0);
            state   <= (distance_high != 32'd0) ? F_DIV : F_PUSH;
          end
        end
        F_DIV: begin
          rem <= fits ? 32'(shifted - {1'b0, divisor}) : shifted[31:0];
          quo <= {quo[30:0], fits};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign in_ready            = (state == F_IDLE);
  assign push_valid          = (state == F_PUSH);
  assign push_item.has_probe = has;
  assign push_item.probe     = quo[31:1];

endmodule

`default_nettype wire

/* sv/tmpe_queue.sv */
// ----------------------------------------------------------------------------
// tmpe_queue
// Two-entry queue of probe items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tmpe_queue import tmpe_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  wire probe_item_t wr_item,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output probe_item_t rd_item
);

  probe_item_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_item  = entry[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      case ({do_wr, do_rd})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/tmpe_back.sv */
// ----------------------------------------------------------------------------
// tmpe_back
// Window update (dedup, sorted merge, ring), trimmed sum, mean and scaling.
// ----------------------------------------------------------------------------
`default_nettype none
`include "trimmed_mean_population_estimator_core_defines.svh"

module tmpe_back import tmpe_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   pop_valid,
  output logic        pop_ready,
  input  wire probe_item_t pop_item,
  output logic        out_valid,
  input  wire logic   out_ready,
  output result_t     out_data
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_OLD    = 4'd1;
  localparam logic [3:0] ST_MA     = 4'd2;
  localparam logic [3:0] ST_MB     = 4'd3;
  localparam logic [3:0] ST_ADDEND = 4'd4;
  localparam logic [3:0] ST_SSET   = 4'd5;
  localparam logic [3:0] ST_SA     = 4'd6;
  localparam logic [3:0] ST_SB     = 4'd7;
  localparam logic [3:0] ST_DIV    = 4'd8;
  localparam logic [3:0] ST_MOD1   = 4'd9;
  localparam logic [3:0] ST_MOD2   = 4'd10;
  localparam logic [3:0] ST_MUL1   = 4'd11;
  localparam logic [3:0] ST_MUL2   = 4'd12;
  localparam logic [3:0] ST_MUL3   = 4'd13;
  localparam logic [3:0] ST_OUT    = 4'd14;

  localparam int DCNT_W = $clog2(SUM_W + 1);

  logic [3:0]         state;
  logic [PROBE_W-1:0] p;
  logic [PROBE_W-1:0] o;
  logic               del;
  logic               ins;
  logic               added;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   j;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   end_k;
  logic [CNT_W-1:0]   kept;
  logic [ADDR_W-1:0]  newest;
  logic               bank;
  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   rem;
  logic [SUM_W-1:0]   quo;
  logic [DCNT_W-1:0]  dcnt;
  logic [MOD_W-1:0]   mod_a;
  logic [MOD_W-1:0]   mod_b;
  logic [MOD_W-1:0]   mod_m;
  logic [46:0]        p_lo;
  logic [48:0]        p_hi;
  logic [31:0]        est;

  // sorted banks and ring
  logic               sw_en;
  logic [PROBE_W-1:0] sw_data;
  logic [PROBE_W-1:0] rd0;
  logic [PROBE_W-1:0] rd1;
  logic [PROBE_W-1:0] srd;
  logic [PROBE_W-1:0] ring_rd;
  logic [ADDR_W-1:0]  oldest;
  logic [ADDR_W-1:0]  newest_inc;

  assign newest_inc = (newest == ADDR_W'(WINDOW - 1)) ? '0 : newest + ADDR_W'(1);
  assign oldest     = newest_inc;
  assign srd        = bank ? rd1 : rd0;

  tmpe_ram #(.WIDTH(PROBE_W), .DEPTH(WINDOW)) u_sort0 (
    .clk(clk), .we(sw_en && bank), .waddr(j[ADDR_W-1:0]), .wdata(sw_data),
    .raddr(k[ADDR_W-1:0]), .rdata(rd0)
  );

  tmpe_ram #(.WIDTH(PROBE_W), .DEPTH(WINDOW)) u_sort1 (
    .clk(clk), .we(sw_en && !bank), .waddr(j[ADDR_W-1:0]), .wdata(sw_data),
    .raddr(k[ADDR_W-1:0]), .rdata(rd1)
  );

  tmpe_ram #(.WIDTH(PROBE_W), .DEPTH(WINDOW)) u_ring (
    .clk(clk), .we(state == ST_ADDEND), .waddr(newest_inc), .wdata(p),
    .raddr(oldest), .rdata(ring_rd)
  );

  // merge write: probe ahead of first larger entry or at the end, else entry
  always_comb begin
    sw_en   = 1'b0;
    sw_data = srd;
    if (state == ST_MA && k == n && !ins) begin
      sw_en   = 1'b1;
      sw_data = p;
    end else if (state == ST_MB && srd != p && !(del && srd == o)) begin
      sw_en   = 1'b1;
      sw_data = (!ins && p < srd) ? p : srd;
    end
  end

  // trim bounds
  logic [CNT_W+7:0] cut_prod;
  logic [CNT_W-1:0] cut;
  assign cut_prod = (CNT_W+8)'(n) * (CNT_W+8)'(CUT_RECIP);
  assign cut      = CNT_W'(cut_prod >> CUT_SHIFT);

  // divider step
  logic [CNT_W:0] dshift;
  logic           dfit;
  assign dshift = {rem, quo[SUM_W-1]};
  assign dfit   = dshift >= {1'b0, kept};

  // modifier terms
  logic [16:0] r_sat;
  logic [16:0] newmod;
  assign r_sat  = (cfg.newer_node_ratio_q16 > ONE_Q16) ? ONE_Q16 : cfg.newer_node_ratio_q16;
  assign newmod = cfg.firewalled_udp ? MOD_FW_Q16 :
                  (cfg.firewalled_ratio_q16 != 16'd0) ?
                  ONE_Q16 + {1'b0, cfg.firewalled_ratio_q16} : 17'd0;

  logic [PROBE_W-1:0] mean;
  logic [64:0]        total;
  assign mean  = quo[PROBE_W-1:0];
  assign total = {p_hi, 16'd0} + {18'd0, p_lo};

  assign pop_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      n         <= '0;
      newest    <= '0;
      bank      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // ST_OUT owns out_valid while a new result is loaded
      if (out_valid && out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            p     <= pop_item.probe;
            added <= 1'b0;
            k     <= '0;
            j     <= '0;
            ins   <= 1'b0;
            del   <= (n == CNT_W'(WINDOW));
            if (!pop_item.has_probe) begin
              state <= ST_SSET;
            end else if (n == CNT_W'(WINDOW)) begin
              state <= ST_OLD;
            end else begin
              state <= ST_MA;
            end
          end
        end
        ST_OLD: begin
          o     <= ring_rd;
          state <= ST_MA;
        end
        ST_MA: begin
          if (k == n) begin
            if (!ins) j <= j + CNT_W'(1);
            state <= ST_ADDEND;
          end else begin
            state <= ST_MB;
          end
        end
        ST_MB: begin
          if (srd == p) begin
            state <= ST_SSET;            // already held: window unchanged
          end else if (del && srd == o) begin
            k     <= k + CNT_W'(1);
            state <= ST_MA;
          end else if (!ins && p < srd) begin
            j   <= j + CNT_W'(1);
            ins <= 1'b1;
          end else begin
            j     <= j + CNT_W'(1);
            k     <= k + CNT_W'(1);
            state <= ST_MA;
          end
        end
        ST_ADDEND: begin
          newest <= newest_inc;
          bank   <= ~bank;
          n      <= j;
          added  <= 1'b1;
          state  <= ST_SSET;
        end
        ST_SSET: begin
          if (n < CNT_W'(MIN_SAMPLES)) begin
            est   <= '0;
            state <= ST_OUT;
          end else begin
            k     <= cut;
            end_k <= n - cut;
            kept  <= n - CNT_W'({cut, 1'b0});
            sum   <= '0;
            state <= ST_SA;
          end
        end
        ST_SA: begin
          if (k == end_k) begin
            quo   <= sum;
            rem   <= '0;
            dcnt  <= '0;
            state <= ST_DIV;
          end else begin
            state <= ST_SB;
          end
        end
        ST_SB: begin
          sum   <= sum + SUM_W'(srd);
          k     <= k + CNT_W'(1);
          state <= ST_SA;
        end
        ST_DIV: begin
          rem  <= dfit ? CNT_W'(dshift - {1'b0, kept}) : dshift[CNT_W-1:0];
          quo  <= {quo[SUM_W-2:0], dfit};
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(SUM_W - 1)) begin
            state <= ST_MOD1;
          end
        end
        ST_MOD1: begin
          mod_a <= MOD_W'(r_sat * newmod);
          mod_b <= MOD_W'((ONE_Q16 - r_sat) * MOD_OLD_Q16);
          state <= ST_MOD2;
        end
        ST_MOD2: begin
          mod_m <= (r_sat != 17'd0 && newmod != 17'd0) ? mod_a + mod_b :
                   MOD_W'({MOD_OLD_Q16, 16'd0});
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          p_lo  <= 47'(mean * mod_m[15:0]);
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          p_hi  <= 49'(mean * mod_m[MOD_W-1:16]);
          state <= ST_MUL3;
        end
        ST_MUL3: begin
          est   <= total[64] ? 32'hFFFF_FFFF : total[63:32];
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_data.estimate    <= est;
            out_data.probe_count <= 7'(n);
            out_data.probe_added <= added;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TMPE_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, n <= CNT_W'(WINDOW), "window count overflow")
  `TMPE_ASSERT_IMP(a_merge_read, clk, rst, state == ST_MB, k < n, "merge read past count")
  `TMPE_ASSERT_IMP(a_merge_wr, clk, rst, state == ST_MB, (CNT_W+1)'(j) <= (CNT_W+1)'(k) + 1'b1, "merge write ran ahead")
  `TMPE_ASSERT_NXT(a_ring_adv, clk, rst, state == ST_ADDEND, newest != $past(newest), "ring pointer stuck")

endmodule

`default_nettype wire
